FILE: src/md5_pkg.sv
package md5_pkg;

  localparam logic [1:0] ACT_ABSORB = 2'd0;
  localparam logic [1:0] ACT_ABS_FIN = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } md5_cmd_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_res_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

FILE: src/md5_if.sv
interface md5_cmd_if;
  logic valid;
  logic ready;
  md5_pkg::md5_cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface md5_res_if;
  logic valid;
  logic ready;
  md5_pkg::md5_res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/md5_ram.sv
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/md5_front.sv
module md5_front (
  input  logic               clk,
  input  logic               rst_n,
  md5_cmd_if.sink            in_ch,
  output logic               q_valid,
  output md5_pkg::md5_cmd_t  q_data,
  input  logic               q_pop
);
  import md5_pkg::*;

  md5_cmd_t         q_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             push;

  assign in_ch.ready = (cnt_r != 3'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready && (in_ch.payload.action != ACT_UNUSED);
  assign q_valid = (cnt_r != '0);
  assign q_data = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) cnt_nxt = cnt_r + 1'b1;
    if (!push && q_pop && q_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
    end
    if (push) q_r[wp_r] <= in_ch.payload;
  end
endmodule

FILE: src/md5_back.sv
module md5_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  md5_pkg::md5_cmd_t  q_data,
  output logic               q_pop,
  md5_res_if.source          out_ch
);
  import md5_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_RND   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] ch_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [63:0] len_r;
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic        ptail_r;
  logic        lenblk_r;
  logic        done_r;
  logic [1:0]  oidx_r;
  logic [23:0] wacc_r;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  logic        wr_byte;
  logic [7:0]  wbyte;

  md5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] fval, sum, rot;
  logic [4:0]  sh;

  always_comb begin
    case (rnd_r[5:4])
      2'd0: fval = (b_r & c_r) | (~b_r & d_r);
      2'd1: fval = (b_r & d_r) | (c_r & ~d_r);
      2'd2: fval = b_r ^ c_r ^ d_r;
      default: fval = c_r ^ (b_r | ~d_r);
    endcase
    sum = a_r + fval + round_k(rnd_r) + rdata;
    sh = round_s(rnd_r);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  // Gather bytes of a word; store the word with its fourth byte.
  always_comb begin
    wr_byte = 1'b0;
    wbyte = q_data.data_byte;
    if (st_r == ST_IDLE) begin
      wr_byte = q_valid && (q_data.action != ACT_FINISH);
    end else if (st_r == ST_PAD) begin
      wr_byte = 1'b1;
      if (!ptail_r) wbyte = 8'h80;
      else if (lenblk_r && pos_r[5:3] == 3'b111) wbyte = len_r[{pos_r[2:0], 3'b000} +: 8];
      else wbyte = 8'h00;
    end
    we = wr_byte && (pos_r[1:0] == 2'b11);
    waddr = pos_r[5:2];
    wdata = {wbyte, wacc_r};
    raddr = (st_r == ST_RND) ? round_g(rnd_r + 6'd1) : 4'd0;
  end

  always_comb begin
    q_pop = 1'b0;
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (q_data.action != ACT_FINISH && pos_r == 6'd63) st_nxt = ST_RND;
        else if (q_data.action != ACT_ABSORB) st_nxt = ST_PAD;
      end
      ST_PAD: if (pos_r == 6'd63) st_nxt = ST_RND;
      ST_RND: if (rnd_r == 6'd63) st_nxt = ST_ADD;
      ST_ADD: if (!fin_r) st_nxt = ST_IDLE;
        else if (done_r) st_nxt = ST_OUT;
        else st_nxt = ST_PAD;
      ST_OUT: if (out_ch.ready && oidx_r == 2'd3) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ch_r[0] <= INIT_A; ch_r[1] <= INIT_B; ch_r[2] <= INIT_C; ch_r[3] <= INIT_D;
      len_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      ptail_r <= 1'b0;
      lenblk_r <= 1'b0;
      done_r <= 1'b0;
      oidx_r <= '0;
      wacc_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (wr_byte) begin
        pos_r <= pos_r + 6'd1;
        if (pos_r[1:0] != 2'b11) wacc_r[{pos_r[1:0], 3'b000} +: 8] <= wbyte;
        if (pos_r == 6'd63) begin
          {a_r, b_r, c_r, d_r} <= {ch_r[0], ch_r[1], ch_r[2], ch_r[3]};
          rnd_r <= '0;
        end
      end
      case (st_r)
        ST_IDLE: if (q_valid) begin
          fin_r <= (q_data.action != ACT_ABSORB);
          ptail_r <= 1'b0;
          done_r <= 1'b0;
          if (q_data.action != ACT_FINISH) len_r <= len_r + 64'd8;
        end
        ST_PAD: begin
          if (!ptail_r) begin
            ptail_r <= 1'b1;
            lenblk_r <= (pos_r <= 6'd55);
          end
          if (pos_r == 6'd63) begin
            done_r <= ptail_r && lenblk_r;
            lenblk_r <= 1'b1;
          end
        end
        ST_RND: begin
          a_r <= d_r;
          d_r <= c_r;
          c_r <= b_r;
          b_r <= b_r + rot;
          rnd_r <= rnd_r + 1'b1;
        end
        ST_ADD: begin
          ch_r[0] <= ch_r[0] + a_r;
          ch_r[1] <= ch_r[1] + b_r;
          ch_r[2] <= ch_r[2] + c_r;
          ch_r[3] <= ch_r[3] + d_r;
          oidx_r <= '0;
        end
        ST_OUT: if (out_ch.ready) begin
          oidx_r <= oidx_r + 1'b1;
          if (oidx_r == 2'd3) begin
            ch_r[0] <= INIT_A; ch_r[1] <= INIT_B; ch_r[2] <= INIT_C; ch_r[3] <= INIT_D;
            len_r <= '0;
            pos_r <= '0;
            fin_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = (st_r == ST_OUT);
  assign out_ch.payload.digest_word = ch_r[oidx_r];
  assign out_ch.payload.word_index = oidx_r;
  assign out_ch.payload.last_word = (oidx_r == 2'd3);
endmodule

FILE: src/md5_hash_engine.sv
// Queue: an item is registered in the four-entry queue before the back end pops it.
// Throughput: one byte per cycle while the back end is idle; the 64th byte of a block
// starts 64 rounds and one add, during which the queue holds.
// Finish: pad and length bytes fill the block end, and each padded block (one or two)
// runs its rounds and add; then four digest words, one per cycle while out_ready is high.
// Synchronous active-low reset restores the MD5 initial chain and zero length.
module md5_hash_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0] out_word_index,
  output logic       out_last_word
);
  import md5_pkg::*;

  md5_cmd_if in_ch ();
  md5_res_if out_ch ();
  logic      q_valid, q_pop;
  md5_cmd_t  q_data;

  assign in_ch.valid = in_valid;
  assign in_ch.payload.action = in_action;
  assign in_ch.payload.data_byte = in_data_byte;
  assign in_ready = in_ch.ready;
  assign out_valid = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_digest_word = out_ch.payload.digest_word;
  assign out_word_index = out_ch.payload.word_index;
  assign out_last_word = out_ch.payload.last_word;

  md5_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  md5_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3)))
    else $error("last_word mismatch");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_idx_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_word_index != 2'd3) |=> out_valid)
    else $error("digest words broken");
endmodule
